[hw/rtl/olsu_pkg.sv]
// Package for the ordered list store: command and status codes, the
// per-cell control word shared by the cell chain and the top level.
// No dependencies.
package olsu_pkg;

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COUNT    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_TAIL = 3'd5;
    localparam logic [CMD_W-1:0] CMD_DEL_POS  = 3'd6;
    localparam logic [CMD_W-1:0] CMD_DEL_VAL  = 3'd7;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    // Broadcast to every cell: open a gap, close a gap, and the word to store
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [DATA_W-1:0] data;
    } cell_ctl_t;

endpackage

[hw/rtl/ordered_list_store_unit.sv]
// Top level of the ordered list store: command sequencer, fill count and
// the chain of list cells. Depends on olsu_pkg and olsu_cell.
//
// Usage:
//   A command word (cmd, value, position) is taken at a rising edge where
//   start is high and busy is low. busy is high for the one cycle in which
//   every cell compares its entry with value. In the next cycle the cells
//   shift in one step (insert opens a gap, delete at head, position or
//   value closes one) and the result word is registered; it shows on
//   status, match_count and length for exactly one cycle with done high.
//   done is registered from the execute state. A new command may be
//   accepted in the cycle where the previous one executes, so commands
//   overlap: each passes the registered compare in each cell, then the
//   shift step of the chain.
//   The receiver cannot stall: done is a one-cycle strobe.
//   Reset empties the list (fill count 0) and clears done; length is not
//   reset, and entries hold no meaning until written and need no clearing.
module ordered_list_store_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [olsu_pkg::CMD_W-1:0]    cmd,
    input  logic signed [olsu_pkg::DATA_W-1:0] value,
    input  logic [olsu_pkg::POS_W-1:0]    position,
    output logic                          done,
    output logic [olsu_pkg::STATUS_W-1:0] status,
    output logic [olsu_pkg::COUNT_W-1:0]  match_count,
    output logic [olsu_pkg::COUNT_W-1:0]  length
);
    import olsu_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int SW    = CNT_W + COUNT_W;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXE  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CMD_W-1:0]    cmd_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                done_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [COUNT_W-1:0]  mcount_reg, mcount_next;
    logic [COUNT_W-1:0]  length_reg, length_next;

    logic [DATA_W-1:0]   entries [CAPACITY];
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] hit_vec;
    cell_ctl_t           ctl;
    logic [CNT_W-1:0]    op_idx;

    logic                accept;
    logic                full, empty;
    logic [EW-1:0]       pos_e, fill_e;
    logic [CNT_W-1:0]    hit_cnt;
    logic [CNT_W-1:0]    first_idx;
    logic                found;
    logic [CNT_W-1:0]    mcnt;

    assign accept = start && !busy;
    assign busy   = (state_reg == S_CMP);

    // Cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_w, right_w;
        if (i == 0)
        begin : g_first
            assign left_w = entries[i];
        end
        else
        begin : g_mid_l
            assign left_w = entries[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = entries[i];
        end
        else
        begin : g_mid_r
            assign right_w = entries[i+1];
        end

        olsu_cell #(
            .INDEX (i),
            .IDX_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .idx         (op_idx),
            .cmp_value   (value_reg),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entries[i]),
            .match       (match_vec[i])
        );

        // Only held entries count as hits
        assign hit_vec[i] = match_vec[i] && (CNT_W'(i) < fill_reg);
    end

    // Hit count and first hit
    always_comb
    begin
        hit_cnt   = '0;
        first_idx = '0;
        found     = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            hit_cnt = hit_cnt + CNT_W'(hit_vec[i]);
            if (hit_vec[i])
            begin
                first_idx = CNT_W'(i);
                found     = 1'b1;
            end
        end
    end

    assign full   = (fill_reg == CAP);
    assign empty  = (fill_reg == '0);
    assign pos_e  = EW'(pos_reg);
    assign fill_e = EW'(fill_reg);

    // Command decode, active in the execute cycle
    always_comb
    begin
        ctl.ins     = 1'b0;
        ctl.del     = 1'b0;
        ctl.data    = value_reg;
        op_idx      = '0;
        fill_next   = fill_reg;
        status_next = ST_OK;
        mcnt        = '0;
        if (state_reg == S_EXE)
        begin
            case (cmd_reg)
                CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS:
                begin
                    if (cmd_reg == CMD_INS_POS &&
                        (pos_e == '0 || pos_e > fill_e + EW'(1)))
                        status_next = ST_BADPOS;
                    else if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        ctl.ins   = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                        if (cmd_reg == CMD_INS_TAIL)
                            op_idx = fill_reg;
                        else if (cmd_reg == CMD_INS_POS)
                            op_idx = CNT_W'(pos_e - EW'(1));
                    end
                end
                CMD_COUNT:
                    mcnt = hit_cnt;
                CMD_DEL_HEAD, CMD_DEL_TAIL:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        ctl.del   = (cmd_reg == CMD_DEL_HEAD);
                        fill_next = fill_reg - CNT_W'(1);
                    end
                end
                CMD_DEL_POS:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (pos_e == '0 || pos_e > fill_e)
                        status_next = ST_BADPOS;
                    else
                    begin
                        ctl.del   = 1'b1;
                        op_idx    = CNT_W'(pos_e - EW'(1));
                        fill_next = fill_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (!found)
                        status_next = ST_NOTFOUND;
                    else
                    begin
                        ctl.del   = 1'b1;
                        op_idx    = first_idx;
                        fill_next = fill_reg - CNT_W'(1);
                    end
                end
            endcase
        end
    end

    // Saturate counts to the 5-bit result fields
    always_comb
    begin
        logic [SW-1:0] m_e, l_e;
        m_e         = SW'(mcnt);
        l_e         = SW'(fill_next);
        mcount_next = (m_e > SW'(31)) ? COUNT_W'(31) : m_e[COUNT_W-1:0];
        length_next = (l_e > SW'(31)) ? COUNT_W'(31) : l_e[COUNT_W-1:0];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = accept ? S_CMP : S_IDLE;
            S_CMP:   state_next = S_EXE;
            S_EXE:   state_next = accept ? S_CMP : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= (state_reg == S_EXE);
        end
    end

    // Command and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            value_reg <= value;
            pos_reg   <= position;
        end
        if (state_reg == S_EXE)
        begin
            status_reg <= status_next;
            mcount_reg <= mcount_next;
            length_reg <= length_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign match_count = mcount_reg;
    assign length      = length_reg;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CAP)
        else $error("fill count above capacity");

    a_exe_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXE) |=> done_reg)
        else $error("execute cycle gave no done strobe");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted command did not enter compare");

    a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXE) |=> $stable(fill_reg))
        else $error("fill count changed outside execute");

endmodule

[hw/rtl/olsu_cell.sv]
// One list slot of the ordered list store: holds an entry, loads the new
// word or one from its left or right neighbor on insert/delete, registers a
// match flag. Depends on olsu_pkg.
module olsu_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 5
) (
    input  logic                       clk,
    input  olsu_pkg::cell_ctl_t        ctl,
    input  logic [IDX_W-1:0]           idx,
    input  logic [olsu_pkg::DATA_W-1:0] cmp_value,
    input  logic [olsu_pkg::DATA_W-1:0] left_entry,
    input  logic [olsu_pkg::DATA_W-1:0] right_entry,
    output logic [olsu_pkg::DATA_W-1:0] entry,
    output logic                       match
);
    import olsu_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic              match_reg;

    // Shift or load decision from the broadcast index
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins)
        begin
            if (MY_IDX == idx)
                entry_next = ctl.data;
            else if (MY_IDX > idx)
                entry_next = left_entry;
        end
        else if (ctl.del)
        begin
            if (MY_IDX >= idx)
                entry_next = right_entry;
        end
    end

    // Entry and compare registers, payload only
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= (entry_reg == cmp_value);
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule
